FILE: hdl/bitmap_block_allocator_unit_assert.svh
// assertion macros used by the allocator top level
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is held
`define BBA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, also checked through reset
`define BBA_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: hdl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    // sizes of the fixed fields
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;

    localparam int          MAX_BLOCKS_DEF = 1024;
    localparam logic [10:0] COUNT_RESET    = 11'd1024;

    // command codes
    localparam logic [1:0] CMD_CLEAR_ALL = 2'd0;
    localparam logic [1:0] CMD_FIND_FREE = 2'd1;
    localparam logic [1:0] CMD_MARK_USED = 2'd2;
    localparam logic [1:0] CMD_MARK_FREE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // one finished result
    typedef struct packed {
        logic [INDEX_W-1:0]  free_index;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

FILE: hdl/bitmap_block_allocator_unit.sv
`timescale 1ns / 1ps
// channel   direction  contents
// s_        in         request: command in tuser, block index in tdata
// m_        out        result: status in tuser, free index in tdata
// cfg_      in         block count register write
//
// mark_used / mark_free go through read, then modify and write, then hand over.
// clear_all and find_free sweep the bitmap one byte per cycle through the single
// read port; find_free stops at the first byte that holds a free block.
// after reset the store is swept to zero with s_tready low.
// a new request is taken while a result waits in the output register.

`include "bitmap_block_allocator_unit_assert.svh"

module bitmap_block_allocator_unit #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config register
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] block_index, [15:10] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] free_index, [15:10] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int STORE_BYTES = (MAX_BLOCKS + 7) / 8;
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int MW = (CW > bba_pkg::COUNT_W) ? CW : bba_pkg::COUNT_W;

    logic [bba_pkg::COUNT_W-1:0] count_reg;
    logic [CW-1:0]               live_cnt;
    logic                        m_tvalid_reg;
    bba_pkg::result_t            out_reg;
    logic                        res_valid;
    logic                        res_ready;
    bba_pkg::result_t            res;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [7:0]                  mem_rdata;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [7:0]                  mem_wdata;

    // block count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= bba_pkg::COUNT_RESET;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // count in effect saturates at MAX_BLOCKS
    assign live_cnt = (MW'(count_reg) > MW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_reg);

    bba_ctrl #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cnt       (live_cnt),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_idx    (s_tdata[9:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    bba_mem #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_reg.free_index};
    assign m_tuser  = out_reg.status;

    // checks
    `BBA_ASSERT_IMPL(a_index_only_ok, aclk, aresetn,
        m_tvalid && (m_tuser != bba_pkg::ST_OK), m_tdata == 16'd0)
    `BBA_ASSERT_NEXT(a_busy_after_reset, aclk, !aresetn, !s_tready)
    `BBA_ASSERT_NEXT(a_busy_after_request, aclk, aresetn && s_tvalid && s_tready, !s_tready)

endmodule

FILE: hdl/bba_mem.sv
`timescale 1ns / 1ps

module bba_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/bba_ctrl.sv
`timescale 1ns / 1ps

module bba_ctrl #(
    parameter int STORE_BYTES = 128,
    parameter int AW          = 7,
    parameter int CW          = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [CW-1:0]                 cnt,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bba_pkg::CMD_W-1:0]     in_cmd,
    input  logic [bba_pkg::INDEX_W-1:0]   in_idx,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bba_pkg::result_t              res,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_raddr,
    input  logic [7:0]                    mem_rdata,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [7:0]                    mem_wdata
);

    localparam logic [2:0] S_INIT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_MARK_RD = 3'd2;
    localparam logic [2:0] S_MARK_WR = 3'd3;
    localparam logic [2:0] S_SCAN    = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    localparam int IW = (CW > bba_pkg::INDEX_W) ? CW : bba_pkg::INDEX_W;

    logic [2:0]                    state_reg, state_next;
    logic [bba_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [bba_pkg::INDEX_W-1:0]   idx_reg, idx_next;
    logic [AW:0]                   rd_ptr_reg, rd_ptr_next;
    logic                          pend_vld_reg, pend_vld_next;
    logic [AW-1:0]                 pend_addr_reg, pend_addr_next;
    logic [AW-1:0]                 init_ptr_reg, init_ptr_next;
    bba_pkg::result_t              res_reg, res_next;

    logic [CW:0]     cnt_p7;
    logic [AW:0]     nbytes;
    logic [AW:0]     full_bytes;
    logic [2:0]      rem;
    logic            partial;
    logic [7:0]      in_mask;
    logic [7:0]      free_bits;
    logic            hit;
    logic [2:0]      pos;
    logic            last_byte;
    logic            idx_out;
    logic [AW-1:0]   idx_addr;
    logic [7:0]      idx_bit;

    // bytes covered by the count and the partial tail byte
    assign cnt_p7     = {1'b0, cnt} + (CW+1)'(7);
    assign nbytes     = (AW+1)'(cnt_p7 >> 3);
    assign full_bytes = (AW+1)'(cnt >> 3);
    assign rem        = cnt[2:0];
    assign partial    = ({1'b0, pend_addr_reg} == full_bytes);
    assign in_mask    = partial ? ~(8'hFF >> rem) : 8'hFF;
    assign last_byte  = ({1'b0, pend_addr_reg} == (nbytes - (AW+1)'(1)));

    // free marks of the byte just read, lowest block first from the msb
    assign free_bits = ~mem_rdata & in_mask;
    assign hit       = |free_bits;

    always_comb begin
        pos = 3'd0;
        for (int off = 7; off >= 0; off--) begin
            if (free_bits[7-off]) begin
                pos = 3'(off);
            end
        end
    end

    // single-block mark address and bit
    assign idx_out  = (IW'(in_idx) >= IW'(cnt));
    assign idx_addr = AW'(idx_reg >> 3);
    assign idx_bit  = 8'h80 >> idx_reg[2:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_vld_next  = pend_vld_reg;
        pend_addr_next = pend_addr_reg;
        init_ptr_next  = init_ptr_reg;
        res_next       = res_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg[AW-1:0];
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = 8'h00;
        unique case (state_reg)
            S_INIT: begin
                mem_we        = 1'b1;
                mem_waddr     = init_ptr_reg;
                init_ptr_next = init_ptr_reg + AW'(1);
                if (init_ptr_reg == AW'(STORE_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next      = in_cmd;
                    idx_next      = in_idx;
                    rd_ptr_next   = '0;
                    pend_vld_next = 1'b0;
                    res_next      = '{free_index: '0, status: bba_pkg::ST_OK};
                    unique case (in_cmd)
                        bba_pkg::CMD_CLEAR_ALL: begin
                            state_next = (nbytes == '0) ? S_DONE : S_SCAN;
                        end
                        bba_pkg::CMD_FIND_FREE: begin
                            if (nbytes == '0) begin
                                res_next.status = bba_pkg::ST_NONE;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            if (idx_out) begin
                                res_next.status = bba_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_MARK_RD;
                            end
                        end
                    endcase
                end
            end
            S_MARK_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = idx_addr;
                state_next = S_MARK_WR;
            end
            S_MARK_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_addr;
                mem_wdata  = (cmd_reg == bba_pkg::CMD_MARK_USED) ?
                             (mem_rdata | idx_bit) : (mem_rdata & ~idx_bit);
                state_next = S_DONE;
            end
            S_SCAN: begin
                // keep one byte read ahead of the one being checked
                pend_vld_next = 1'b0;
                if (rd_ptr_reg < nbytes) begin
                    mem_re         = 1'b1;
                    rd_ptr_next    = rd_ptr_reg + (AW+1)'(1);
                    pend_vld_next  = 1'b1;
                    pend_addr_next = rd_ptr_reg[AW-1:0];
                end
                if (pend_vld_reg) begin
                    if (cmd_reg == bba_pkg::CMD_CLEAR_ALL) begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata & ~in_mask;
                        if (last_byte) begin
                            pend_vld_next = 1'b0;
                            state_next    = S_DONE;
                        end
                    end else if (hit) begin
                        res_next.free_index = bba_pkg::INDEX_W'({pend_addr_reg, pos});
                        pend_vld_next       = 1'b0;
                        state_next          = S_DONE;
                    end else if (last_byte) begin
                        res_next.status = bba_pkg::ST_NONE;
                        pend_vld_next   = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            init_ptr_reg <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_ptr_reg <= init_ptr_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    // request and scan payload
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        rd_ptr_reg    <= rd_ptr_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
    end

endmodule

FILE: bench/tb_bitmap_block_allocator_unit.sv
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_unit;

    // usage map mirror and queue of pending allocator answers
    class alloc_scoreboard;
        bit [7:0]         usage_map [bba_pkg::MAX_BLOCKS_DEF/8];
        int unsigned      live_blocks;
        bba_pkg::result_t answer_q [$];
        int unsigned      mismatches;
        int unsigned      requests_seen;
        int unsigned      results_seen;
        int unsigned      none_expected;
        int unsigned      range_expected;

        function new();
            foreach (usage_map[i]) usage_map[i] = 8'h00;
            live_blocks    = bba_pkg::MAX_BLOCKS_DEF;
            mismatches     = 0;
            requests_seen  = 0;
            results_seen   = 0;
            none_expected  = 0;
            range_expected = 0;
        endfunction

        // count above the store size saturates
        function void set_count(logic [10:0] count);
            live_blocks = (count > bba_pkg::MAX_BLOCKS_DEF) ? bba_pkg::MAX_BLOCKS_DEF : count;
        endfunction

        function int pending();
            return answer_q.size();
        endfunction

        // msb first: block n is bit 7 - n%8 of byte n/8
        function int first_free();
            for (int n = 0; n < live_blocks; n++) begin
                if (!usage_map[n >> 3][7 - (n & 7)])
                    return n;
            end
            return -1;
        endfunction

        function void note_request(logic [1:0] command, logic [9:0] idx);
            bba_pkg::result_t answer;
            int               lowest;
            answer = '0;
            answer.status = bba_pkg::ST_OK;
            requests_seen++;
            case (command)
                bba_pkg::CMD_CLEAR_ALL: begin
                    for (int n = 0; n < live_blocks; n++)
                        usage_map[n >> 3][7 - (n & 7)] = 1'b0;
                end
                bba_pkg::CMD_FIND_FREE: begin
                    lowest = first_free();
                    if (lowest < 0)
                        answer.status = bba_pkg::ST_NONE;
                    else
                        answer.free_index = lowest[9:0];
                end
                bba_pkg::CMD_MARK_USED: begin
                    if (idx >= live_blocks)
                        answer.status = bba_pkg::ST_RANGE;
                    else
                        usage_map[idx >> 3][7 - (idx & 7)] = 1'b1;
                end
                bba_pkg::CMD_MARK_FREE: begin
                    if (idx >= live_blocks)
                        answer.status = bba_pkg::ST_RANGE;
                    else
                        usage_map[idx >> 3][7 - (idx & 7)] = 1'b0;
                end
            endcase
            if (answer.status == bba_pkg::ST_NONE) none_expected++;
            if (answer.status == bba_pkg::ST_RANGE) range_expected++;
            answer_q.push_back(answer);
        endfunction

        function void flag(string what, logic [15:0] exp_data, logic [1:0] exp_status,
                           logic [15:0] got_data, logic [1:0] got_status);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch (%s): expected index %0d status %0d, got index %0d status %0d",
                         what, exp_data, exp_status, got_data, got_status);
        endfunction

        function void check_result(logic [15:0] data, logic [1:0] status);
            bba_pkg::result_t answer;
            results_seen++;
            if (answer_q.size() == 0) begin
                flag("no request waiting", 'x, 'x, data, status);
                return;
            end
            answer = answer_q.pop_front();
            if (data !== {6'd0, answer.free_index} || status !== answer.status)
                flag("wrong result", {6'd0, answer.free_index}, answer.status, data, status);
        endfunction

        // requests whose answer never arrived
        function void flush_leftover();
            bba_pkg::result_t answer;
            while (answer_q.size() != 0) begin
                answer = answer_q.pop_front();
                flag("missing result", {6'd0, answer.free_index}, answer.status, 'x, 'x);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [10:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;   // [9:0] block_index, [15:10] zero
    logic [1:0]  s_tuser     = '0;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;            // [9:0] free_index, [15:10] zero
    logic [1:0]  m_tuser;            // [1:0] status

    alloc_scoreboard sb;
    bit              steady;
    int unsigned     sent;
    int unsigned     settings_used;

    bitmap_block_allocator_unit #(
        .MAX_BLOCKS(bba_pkg::MAX_BLOCKS_DEF)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // mostly short gaps, a few long ones, none in steady stretches
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // handshake monitor feeding the scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[9:0]);
        end
    end

    // result side back-pressure
    initial begin
        int unsigned hold;
        bit          ready_now;
        hold      = 0;
        ready_now = 1'b0;
        forever begin
            @(posedge aclk);
            if (steady) begin
                ready_now = 1'b1;
                hold      = 0;
            end else if (hold == 0) begin
                ready_now = !ready_now;
                if (!ready_now)
                    hold = pick_gap() + 1;
                else if ($urandom_range(0, 19) == 0)
                    hold = $urandom_range(100, 300);
                else
                    hold = $urandom_range(1, 24);
            end
            if (hold != 0)
                hold--;
            m_tready <= ready_now;
        end
    end

    task automatic send_request(input logic [1:0] command, input logic [9:0] idx);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= command;
        s_tdata  <= {6'd0, idx};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // hold the request side until every answer is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_block_count(input logic [10:0] count);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_count(count);
        settings_used++;
    endtask

    task automatic run_random_phase(input int unsigned budget);
        int unsigned stop_at;
        int unsigned roll;
        int unsigned run_len;
        int          lowest;
        int          span;
        int          k;
        logic [9:0]  idx;
        stop_at = sent + budget;
        while (sent < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                // allocation burst: claim a run starting at the lowest free block
                lowest  = sb.first_free();
                run_len = $urandom_range(1, 24);
                if (lowest < 0)
                    lowest = 0;
                for (k = 0; k < run_len; k++)
                    send_request(bba_pkg::CMD_MARK_USED, 10'(lowest + k));
                send_request(bba_pkg::CMD_FIND_FREE, 10'($urandom));
            end else if (roll < 48) begin
                send_request(bba_pkg::CMD_FIND_FREE, 10'($urandom));
            end else if (roll < 68) begin
                // release somewhere below or just past the allocation frontier
                lowest = sb.first_free();
                span   = (lowest < 0) ? int'(sb.live_blocks) : lowest + 8;
                idx    = 10'($urandom_range(0, span));
                send_request(bba_pkg::CMD_MARK_FREE, idx);
            end else if (roll < 77) begin
                send_request(bba_pkg::CMD_MARK_USED, 10'($urandom));
            end else if (roll < 85) begin
                send_request(bba_pkg::CMD_MARK_FREE, 10'($urandom));
            end else if (roll < 89) begin
                // just inside or just past the block count
                idx = 10'(sb.live_blocks - $urandom_range(0, 1));
                send_request($urandom_range(0, 1) ? bba_pkg::CMD_MARK_USED :
                             bba_pkg::CMD_MARK_FREE, idx);
            end else if (roll < 91) begin
                send_request(bba_pkg::CMD_CLEAR_ALL, 10'($urandom));
            end else if (roll < 97) begin
                send_request(2'($urandom), 10'($urandom));
            end else if (roll < 98) begin
                wait_drained();
            end else begin
                steady = !steady;
            end
        end
    endtask

    // run control
    initial begin
        logic [10:0] count_plan [7];
        int unsigned budget_plan [7];
        int          k;
        sb            = new();
        steady        = 1'b0;
        sent          = 0;
        settings_used = 0;
        count_plan    = '{11'd1023, 11'd13, 11'd0, 11'd1, 11'd2047, 11'd100, 11'd1024};
        budget_plan   = '{260, 120, 40, 60, 260, 120, 60};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: fresh map, first byte filled bit by bit, top index, clear
        send_request(bba_pkg::CMD_FIND_FREE, 10'd0);
        send_request(bba_pkg::CMD_MARK_USED, 10'd0);
        send_request(bba_pkg::CMD_FIND_FREE, 10'h3FF);
        for (k = 1; k < 8; k++)
            send_request(bba_pkg::CMD_MARK_USED, 10'(k));
        send_request(bba_pkg::CMD_FIND_FREE, 10'd0);
        send_request(bba_pkg::CMD_MARK_USED, 10'h3FF);
        send_request(bba_pkg::CMD_MARK_FREE, 10'h3FF);
        send_request(bba_pkg::CMD_MARK_USED, 10'h3FF);
        send_request(bba_pkg::CMD_MARK_FREE, 10'd3);
        send_request(bba_pkg::CMD_FIND_FREE, 10'd0);
        send_request(bba_pkg::CMD_MARK_FREE, 10'd3);
        send_request(bba_pkg::CMD_MARK_USED, 10'h200);
        send_request(bba_pkg::CMD_CLEAR_ALL, 10'h2AA);
        send_request(bba_pkg::CMD_FIND_FREE, 10'h155);

        run_random_phase(380);
        for (k = 0; k < 7; k++) begin
            write_block_count(count_plan[k]);
            steady = ($urandom_range(0, 3) == 0);
            run_random_phase(budget_plan[k]);
        end

        steady = 1'b0;
        wait_drained();
        repeat (140) @(posedge aclk);
        sb.flush_leftover();

        $display("%0d requests and %0d results over %0d block-count settings",
                 sb.requests_seen, sb.results_seen, settings_used + 1);
        $display("%0d no-free answers and %0d out-of-range rejections expected",
                 sb.none_expected, sb.range_expected);
        if (sb.mismatches == 0) begin
            $display("tb_bitmap_block_allocator_unit: clean");
        end else begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("tb_bitmap_block_allocator_unit: errors");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #25_000_000;
        $display("timeout with %0d answers outstanding", sb.pending());
        $display("tb_bitmap_block_allocator_unit: errors");
        $finish;
    end

endmodule
